FILE: hdl/netprof_pkg.sv
// ----------------------------------------------------------------------------
// netprof_pkg
// Shared constants, opcodes and types of the nested execution time profiler.
// ----------------------------------------------------------------------------
package netprof_pkg;

	localparam int STACK_DEPTH    = 8;
	localparam int OVERHEAD_SHIFT = 4;
	localparam int ADDR_W         = $clog2(STACK_DEPTH);

	localparam int TIME_W  = 32;
	localparam int COUNT_W = 16;
	localparam int OVH_W   = 16;
	localparam int ID_W    = 16;
	localparam int OP_W    = 3;
	localparam int KIND_W  = 2;
	localparam int ERR_W   = 5;
	localparam int DEPTH_W = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// opcodes
	localparam logic [OP_W-1:0] OP_NEST_START  = 3'd0;
	localparam logic [OP_W-1:0] OP_IRQ_FINISH  = 3'd1;
	localparam logic [OP_W-1:0] OP_TASK_FINISH = 3'd2;
	localparam logic [OP_W-1:0] OP_IDLE_START  = 3'd3;
	localparam logic [OP_W-1:0] OP_IDLE_FINISH = 3'd4;
	localparam logic [OP_W-1:0] OP_CRIT_START  = 3'd5;
	localparam logic [OP_W-1:0] OP_CRIT_FINISH = 3'd6;

	// capture kinds
	localparam logic [KIND_W-1:0] KIND_IRQ  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TASK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CRIT = 2'd2;

	// sticky error bits
	localparam int ERR_OVF  = 0;
	localparam int ERR_UDF  = 1;
	localparam int ERR_LT   = 2;
	localparam int ERR_CNT  = 3;
	localparam int ERR_IDLE = 4;

	// register index (paddr[2])
	localparam logic REG_MEASURE = 1'b0;
	localparam logic REG_IRQ     = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0]  measure_start;
		logic [TIME_W-1:0]  task_start;
		logic [TIME_W-1:0]  preempt_time;
		logic [COUNT_W-1:0] preempt_count;
	} frame_t;

	localparam int FRAME_W = $bits(frame_t);

	typedef struct packed {
		logic [OVH_W-1:0] measure_overhead;
		logic [OVH_W-1:0] irq_entry_overhead;
	} cfg_t;

endpackage

FILE: hdl/netprof_ram.sv
// ----------------------------------------------------------------------------
// netprof_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module netprof_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/netprof_core.sv
// ----------------------------------------------------------------------------
// netprof_core
// Frame stack sequencer: reads the top and parent frames from the frame RAM,
// computes the net time, writes the updated frame back and registers the item.
// ----------------------------------------------------------------------------
module netprof_core import netprof_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    opcode,
	input  logic [TIME_W-1:0]  timestamp,
	input  logic [ID_W-1:0]    source_id,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               capture_valid,
	output logic [KIND_W-1:0]  capture_kind,
	output logic [ID_W-1:0]    capture_id,
	output logic [TIME_W-1:0]  capture_time,
	output logic [ERR_W-1:0]   error_status,
	output logic [TIME_W-1:0]  worst_deficit,
	output logic [DEPTH_W-1:0] current_depth
);

	typedef enum logic [2:0] {S_IDLE, S_TOP, S_PAR, S_EVAL, S_DONE} state_t;

	localparam int DW1 = ADDR_W + 1;

	state_t            state_q;
	logic [OP_W-1:0]   op_q;
	logic [TIME_W-1:0] ts_q;
	logic [ID_W-1:0]   id_q;

	logic [ADDR_W-1:0]      depth_q;
	logic [ERR_W-1:0]       sticky_q;
	logic [TIME_W-1:0]      maxdef_q;
	logic [STACK_DEPTH-1:0] valid_q;
	logic [ADDR_W-1:0]      raddr_q;

	// working registers
	frame_t            top_q;
	frame_t            par_q;
	logic [TIME_W-1:0] prod_q;
	logic [TIME_W-1:0] raw_q;
	logic [TIME_W-1:0] cbase_q;
	logic [TIME_W-1:0] ovh_q;
	logic              ok_q;
	logic [TIME_W-1:0] net_q;
	logic [TIME_W-1:0] def_q;
	logic [TIME_W-1:0] charge_q;

	// output register
	logic               out_valid_q;
	logic               cap_valid_q;
	logic [KIND_W-1:0]  cap_kind_q;
	logic [ID_W-1:0]    cap_id_q;
	logic [TIME_W-1:0]  cap_time_q;
	logic [ERR_W-1:0]   err_q;
	logic [TIME_W-1:0]  wdef_q;
	logic [DEPTH_W-1:0] cdepth_q;

	// RAM
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	frame_t            ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [FRAME_W-1:0] ram_rdata;
	frame_t            rd_frame;

	// retire-side next values
	logic              done_fire;
	logic              res_valid;
	logic [KIND_W-1:0] res_kind;
	logic [TIME_W-1:0] res_time;
	logic [ERR_W-1:0]  sticky_n;
	logic [TIME_W-1:0] maxdef_n;
	logic [ADDR_W-1:0] depth_n;
	logic              push_ok;
	logic              depth_zero;

	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] raw0;

	netprof_ram #(
		.WIDTH(FRAME_W),
		.DEPTH(STACK_DEPTH)
	) u_frames (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// a never-written frame reads as its reset value
	assign rd_frame = valid_q[raddr_q] ? frame_t'(ram_rdata) : '0;

	assign in_ready   = (state_q == S_IDLE);
	assign done_fire  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign depth_zero = (depth_q == '0);
	assign push_ok    = (DW1'(depth_q) + DW1'(1)) < DW1'(STACK_DEPTH);

	assign elapsed = ts_q - rd_frame.measure_start;
	assign raw0    = ts_q - rd_frame.task_start;

	always_comb begin
		ram_raddr = depth_q;
		if (state_q == S_IDLE) begin
			case (opcode)
				OP_CRIT_START:  ram_raddr = depth_q + ADDR_W'(1);
				OP_IDLE_START:  ram_raddr = '0;
				OP_IDLE_FINISH: ram_raddr = '0;
				default:        ram_raddr = depth_q;
			endcase
		end else if (state_q == S_TOP) begin
			ram_raddr = depth_q - ADDR_W'(1);
		end
	end

	// retire: frame write-back and result
	always_comb begin
		res_valid = 1'b0;
		res_kind  = '0;
		res_time  = '0;
		sticky_n  = sticky_q;
		maxdef_n  = maxdef_q;
		depth_n   = depth_q;
		ram_we    = 1'b0;
		ram_waddr = depth_q + ADDR_W'(1);
		ram_wdata = '{measure_start: ts_q, task_start: ts_q,
			preempt_time: '0, preempt_count: COUNT_W'(1)};

		// below-overhead check for irq, task and idle finishes
		if (!ok_q && (op_q == OP_IRQ_FINISH || op_q == OP_TASK_FINISH ||
				op_q == OP_IDLE_FINISH)) begin
			if (op_q != OP_IDLE_FINISH ? !depth_zero : depth_zero) begin
				sticky_n[ERR_LT] = 1'b1;
				if (maxdef_q < def_q) begin
					maxdef_n = def_q;
				end
			end
		end

		case (op_q)
			OP_NEST_START, OP_CRIT_START: begin
				if (push_ok) begin
					ram_we  = 1'b1;
					depth_n = depth_q + ADDR_W'(1);
					if (op_q == OP_CRIT_START) begin
						ram_wdata.preempt_time  = top_q.preempt_time;
						ram_wdata.preempt_count = top_q.preempt_count;
					end
				end else begin
					sticky_n[ERR_OVF] = 1'b1;
				end
			end
			OP_IDLE_START: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata.measure_start = top_q.measure_start;
				depth_n   = '0;
			end
			OP_IDLE_FINISH: begin
				if (depth_zero) begin
					res_valid = ok_q;
					res_kind  = KIND_TASK;
					res_time  = net_q;
				end else begin
					sticky_n[ERR_IDLE] = 1'b1;
				end
			end
			OP_IRQ_FINISH, OP_TASK_FINISH, OP_CRIT_FINISH: begin
				if (depth_zero) begin
					sticky_n[ERR_UDF] = 1'b1;
				end else begin
					if (op_q == OP_CRIT_FINISH) begin
						res_valid = 1'b1;
						res_kind  = KIND_CRIT;
						res_time  = raw_q;
					end else begin
						res_valid = ok_q;
						res_kind  = (op_q == OP_IRQ_FINISH) ? KIND_IRQ : KIND_TASK;
						res_time  = net_q;
					end
					ram_we    = 1'b1;
					ram_waddr = depth_q - ADDR_W'(1);
					ram_wdata = par_q;
					ram_wdata.preempt_time = par_q.preempt_time + charge_q;
					if (par_q.preempt_count != COUNT_MAX) begin
						ram_wdata.preempt_count = par_q.preempt_count + COUNT_W'(1);
					end else begin
						sticky_n[ERR_CNT] = 1'b1;
					end
					depth_n = depth_q - ADDR_W'(1);
				end
			end
			default: ;
		endcase

		if (!done_fire) begin
			ram_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			sticky_q    <= '0;
			maxdef_q    <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			cap_valid_q <= 1'b0;
			cap_kind_q  <= '0;
			cap_id_q    <= '0;
			cap_time_q  <= '0;
			err_q       <= '0;
			wdef_q      <= '0;
			cdepth_q    <= '0;
		end else begin
			if (done_fire) begin
				out_valid_q <= 1'b1;
				cap_valid_q <= res_valid;
				cap_kind_q  <= res_valid ? res_kind : '0;
				cap_id_q    <= res_valid ? id_q : '0;
				cap_time_q  <= res_valid ? res_time : '0;
				err_q       <= sticky_n;
				wdef_q      <= maxdef_n;
				cdepth_q    <= DEPTH_W'(depth_n);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					if (((op_q == OP_IRQ_FINISH || op_q == OP_TASK_FINISH ||
							op_q == OP_CRIT_FINISH) && !depth_zero) ||
							(op_q == OP_IDLE_FINISH && depth_zero)) begin
						state_q <= S_PAR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_PAR:  state_q <= S_EVAL;
				S_EVAL: state_q <= S_DONE;
				S_DONE: begin
					if (done_fire) begin
						state_q  <= S_IDLE;
						depth_q  <= depth_n;
						sticky_q <= sticky_n;
						maxdef_q <= maxdef_n;
						if (ram_we) begin
							valid_q[ram_waddr] <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		raddr_q <= ram_raddr;
		if (state_q == S_IDLE && in_valid) begin
			op_q <= opcode;
			ts_q <= timestamp;
			id_q <= source_id;
			ok_q <= 1'b1;
		end
		if (state_q == S_TOP) begin
			top_q  <= rd_frame;
			prod_q <= TIME_W'(rd_frame.preempt_count) * TIME_W'(cfg.measure_overhead);
			raw_q  <= (op_q == OP_IRQ_FINISH) ?
				raw0 + TIME_W'(cfg.irq_entry_overhead) : raw0;
			// task_start - measure_start equals elapsed - raw before the irq term
			cbase_q <= (op_q == OP_IRQ_FINISH) ?
				elapsed + TIME_W'(cfg.irq_entry_overhead) :
				rd_frame.task_start - rd_frame.measure_start;
		end
		if (state_q == S_PAR) begin
			par_q <= rd_frame;
			ovh_q <= (prod_q >> OVERHEAD_SHIFT) + top_q.preempt_time;
		end
		if (state_q == S_EVAL) begin
			ok_q     <= (raw_q >= ovh_q);
			net_q    <= raw_q - ovh_q;
			def_q    <= ovh_q - raw_q;
			charge_q <= (op_q == OP_TASK_FINISH && raw_q >= ovh_q) ?
				cbase_q + ovh_q : cbase_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign capture_valid = cap_valid_q;
	assign capture_kind  = cap_kind_q;
	assign capture_id    = cap_id_q;
	assign capture_time  = cap_time_q;
	assign error_status  = err_q;
	assign worst_deficit = wdef_q;
	assign current_depth = cdepth_q;

endmodule

FILE: hdl/nested_execution_time_profiler.sv
// Sequence: an accepted item steps through S_TOP and S_DONE for starts, ignored items and
// finishes that only raise a flag, else through S_TOP (top frame read and multiply), S_PAR
// (parent frame read through the single read port), S_EVAL (compare) and S_DONE (write-back
// with the result), which waits for out_ready. A new item is taken only back in S_IDLE.
// Reset (async, active low) clears depth, error flags, deficit, result register, configuration
// and the per-frame valid bits, so unwritten frames read as zero; no sweep.
// ----------------------------------------------------------------------------
// nested_execution_time_profiler
// Top level: APB configuration registers around the frame stack sequencer.
// ----------------------------------------------------------------------------
module nested_execution_time_profiler import netprof_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    opcode,
	input  logic [TIME_W-1:0]  timestamp,
	input  logic [ID_W-1:0]    source_id,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               capture_valid,
	output logic [KIND_W-1:0]  capture_kind,
	output logic [ID_W-1:0]    capture_id,
	output logic [TIME_W-1:0]  capture_time,
	output logic [ERR_W-1:0]   error_status,
	output logic [TIME_W-1:0]  worst_deficit,
	output logic [DEPTH_W-1:0] current_depth
);

	cfg_t cfg_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_MEASURE: cfg_q.measure_overhead   <= pwdata[OVH_W-1:0];
				REG_IRQ:     cfg_q.irq_entry_overhead <= pwdata[OVH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MEASURE: prdata = PDATA_W'(cfg_q.measure_overhead);
			REG_IRQ:     prdata = PDATA_W'(cfg_q.irq_entry_overhead);
			default:     prdata = '0;
		endcase
	end

	netprof_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.timestamp    (timestamp),
		.source_id    (source_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.capture_valid(capture_valid),
		.capture_kind (capture_kind),
		.capture_id   (capture_id),
		.capture_time (capture_time),
		.error_status (error_status),
		.worst_deficit(worst_deficit),
		.current_depth(current_depth)
	);

`ifndef SYNTHESIS
	// error flags only ever accumulate
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((error_status & $past(error_status)) == $past(error_status)))
		else $error("error flag cleared");

	a_deficit_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (worst_deficit >= $past(worst_deficit)))
		else $error("worst deficit decreased");

	// an item without a time carries no id, kind or time
	a_empty_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !capture_valid) |->
		(capture_time == '0 && capture_id == '0 && capture_kind == '0))
		else $error("non-captured item has payload");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && capture_valid) |-> (capture_kind != 2'd3))
		else $error("illegal capture kind");
`endif

endmodule
